FILE: src/coe_sdo_object_server_core_assert.svh
// assertion macros used by the sdo object server datapath
// expects signals named clock and reset in the including module
`ifndef COE_SDO_OBJECT_SERVER_CORE_ASSERT_SVH
`define COE_SDO_OBJECT_SERVER_CORE_ASSERT_SVH

// condition implies property in the same cycle
`define COE_SDO_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// condition implies property in the following cycle
`define COE_SDO_ASSERT_NXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: src/coe_sdo_pkg.sv
// types, codes and helpers for the sdo object server
// no dependencies
`timescale 1ns / 1ps

package coe_sdo_pkg;

   typedef struct packed {
      logic        mode;
      logic [7:0]  request_length;
      logic [3:0]  mailbox_type;
      logic [3:0]  coe_service;
      logic [7:0]  command_byte;
      logic [15:0] object_index;
      logic [7:0]  sub_index;
      logic [31:0] data_word;
      logic [2:0]  entry_size;
      logic        entry_writable;
   } req_type;

   typedef struct packed {
      logic [2:0]  response_kind;
      logic [7:0]  control_out;
      logic [15:0] index_out;
      logic [7:0]  sub_out;
      logic [31:0] value_out;
      logic [2:0]  abort_reason;
      logic [2:0]  data_type;
      logic [5:0]  bit_length;
      logic [5:0]  access_flags;
      logic [7:0]  highest_sub;
      logic [3:0]  obj_code;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [23:0] key;
      logic [31:0] value;
      logic [2:0]  size;
      logic        writable;
   } slot_type;

   typedef enum logic [2:0] {
      C_IGNORE, C_DEFINE, C_XFER, C_BAD, C_LIST, C_OBJ, C_ENT
   } req_class_type;

   typedef enum logic [3:0] {
      R_UPLOAD, R_DL_ACK, R_ABORT_MISS, R_ABORT_RO, R_ABORT_BAD,
      R_LIST_HDR, R_LIST_ELEM, R_OBJ_DESC, R_ENT_DESC
   } rsp_sel_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECIDE, S_DEF_SCAN, S_SDO_SCAN, S_ENT_SCAN, S_OBJ_SCAN1,
      S_OBJ_SCAN2, S_CNT_SCAN, S_OUT, S_ELEM0, S_LIST_SCAN
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        start_scan;
      logic        scan_cont;
      logic        key_obj;
      logic        cnt_clear;
      logic        cnt_inc;
      logic        list_init;
      logic        elem_inc;
      logic        write_def;
      logic        write_dl;
      logic        load_out;
      rsp_sel_type out_sel;
      logic        out_last;
   } ctl_type;

   typedef struct packed {
      req_class_type cls;
      logic          scan_busy;
      logic          hit;
      logic          hit_wr;
      logic          is_upload;
      logic          nx_got;
      logic          list_word0;
      logic          n_zero;
      logic          elem_last;
      logic          out_free;
   } sts_type;

   localparam logic [31:0] ABORT_NO_OBJECT = 32'h0602_0000;
   localparam logic [31:0] ABORT_NO_SUB    = 32'h0609_0011;
   localparam logic [31:0] ABORT_READ_ONLY = 32'h0601_0002;
   localparam logic [31:0] ABORT_BAD_CMD   = 32'h0504_0001;

   localparam logic [7:0] CMD_UPLOAD = 8'h43;
   localparam logic [7:0] CMD_DL_ACK = 8'h60;
   localparam logic [7:0] CMD_ABORT  = 8'h80;

   localparam logic [3:0] MBX_COE  = 4'h3;
   localparam logic [3:0] SVC_SDO  = 4'h2;
   localparam logic [3:0] SVC_INFO = 4'h8;
   localparam logic [7:0] MIN_LEN  = 8'd12;
   localparam logic [6:0] OP_MASK  = 7'h7F;
   localparam logic [6:0] OP_LIST  = 7'd1;
   localparam logic [6:0] OP_OBJ   = 7'd3;
   localparam logic [6:0] OP_ENT   = 7'd5;
   localparam logic [2:0] CCS_DOWNLOAD = 3'd1;
   localparam logic [2:0] CCS_UPLOAD   = 3'd2;

   localparam logic [15:0] LIST_LENGTHS = 16'd0;
   localparam logic [15:0] LIST_ALL     = 16'd1;
   localparam int          LENGTHS_COUNT = 5;

   localparam logic [2:0] KIND_UPLOAD   = 3'd0;
   localparam logic [2:0] KIND_DL_ACK   = 3'd1;
   localparam logic [2:0] KIND_ABORT    = 3'd2;
   localparam logic [2:0] KIND_LIST_HDR = 3'd3;
   localparam logic [2:0] KIND_LIST_EL  = 3'd4;
   localparam logic [2:0] KIND_OBJ_DESC = 3'd5;
   localparam logic [2:0] KIND_ENT_DESC = 3'd6;

   localparam logic [2:0] REASON_NONE     = 3'd0;
   localparam logic [2:0] REASON_NO_OBJ   = 3'd1;
   localparam logic [2:0] REASON_NO_SUB   = 3'd2;
   localparam logic [2:0] REASON_RO       = 3'd3;
   localparam logic [2:0] REASON_BAD_CMD  = 3'd4;

   localparam logic [5:0] ACC_READ  = 6'h07;
   localparam logic [5:0] ACC_WRITE = 6'h38;
   localparam logic [3:0] OBJ_VAR   = 4'd7;
   localparam logic [3:0] OBJ_ARRAY = 4'd8;

   function automatic logic [2:0] type_code(input logic [2:0] size);
      logic [2:0] code;
      case (size)
         3'd1: code = 3'd5;
         3'd2: code = 3'd6;
         3'd4: code = 3'd7;
         default: code = 3'd0;
      endcase
      return code;
   endfunction

endpackage

FILE: src/coe_sdo_ctrl.sv
// sequencer for the sdo object server: decodes, runs table scans, orders results
// depends on coe_sdo_pkg
`timescale 1ns / 1ps

module coe_sdo_ctrl import coe_sdo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   state_type   state_ff, state_in;
   rsp_sel_type sel_ff, sel_in;
   logic        last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= R_UPLOAD;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      last_in  = last_ff;
      req_ready = 1'b0;
      ctl = '{capture: 1'b0, start_scan: 1'b0, scan_cont: 1'b0, key_obj: 1'b0,
              cnt_clear: 1'b0, cnt_inc: 1'b0, list_init: 1'b0, elem_inc: 1'b0,
              write_def: 1'b0, write_dl: 1'b0, load_out: 1'b0,
              out_sel: R_UPLOAD, out_last: 1'b0};
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (sts.cls)
               C_DEFINE: begin
                  ctl.start_scan = 1'b1;
                  state_in = S_DEF_SCAN;
               end
               C_XFER: begin
                  ctl.start_scan = 1'b1;
                  state_in = S_SDO_SCAN;
               end
               C_BAD: begin
                  sel_in = R_ABORT_BAD;
                  last_in = 1'b1;
                  state_in = S_OUT;
               end
               C_LIST: begin
                  ctl.start_scan = 1'b1;
                  ctl.cnt_clear = 1'b1;
                  state_in = S_CNT_SCAN;
               end
               C_OBJ: begin
                  ctl.start_scan = 1'b1;
                  state_in = S_OBJ_SCAN1;
               end
               C_ENT: begin
                  ctl.start_scan = 1'b1;
                  state_in = S_ENT_SCAN;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DEF_SCAN: begin
            if (!sts.scan_busy) begin
               ctl.write_def = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SDO_SCAN: begin
            if (!sts.scan_busy) begin
               last_in = 1'b1;
               state_in = S_OUT;
               if (!sts.hit) begin
                  sel_in = R_ABORT_MISS;
               end else if (sts.is_upload) begin
                  sel_in = R_UPLOAD;
               end else if (!sts.hit_wr) begin
                  sel_in = R_ABORT_RO;
               end else begin
                  ctl.write_dl = 1'b1;
                  sel_in = R_DL_ACK;
               end
            end
         end
         S_ENT_SCAN: begin
            if (!sts.scan_busy) begin
               sel_in = R_ENT_DESC;
               last_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OBJ_SCAN1: begin
            // second pass looks up subindex 0 or 1 depending on the highest one
            if (!sts.scan_busy) begin
               ctl.start_scan = 1'b1;
               ctl.key_obj = 1'b1;
               state_in = S_OBJ_SCAN2;
            end
         end
         S_OBJ_SCAN2: begin
            if (!sts.scan_busy) begin
               sel_in = R_OBJ_DESC;
               last_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_CNT_SCAN: begin
            if (!sts.scan_busy) begin
               if (sts.nx_got) begin
                  ctl.cnt_inc = 1'b1;
                  ctl.start_scan = 1'b1;
                  ctl.scan_cont = 1'b1;
               end else begin
                  ctl.list_init = 1'b1;
                  sel_in = R_LIST_HDR;
                  last_in = sts.n_zero;
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               ctl.load_out = 1'b1;
               ctl.out_sel = sel_ff;
               ctl.out_last = last_ff;
               if (last_ff) begin
                  state_in = S_IDLE;
               end else if (sts.list_word0) begin
                  state_in = S_ELEM0;
               end else begin
                  ctl.start_scan = 1'b1;
                  state_in = S_LIST_SCAN;
               end
            end
         end
         S_ELEM0: begin
            if (sts.out_free) begin
               ctl.load_out = 1'b1;
               ctl.out_sel = R_LIST_ELEM;
               ctl.out_last = sts.elem_last;
               ctl.elem_inc = 1'b1;
               if (sts.elem_last) state_in = S_IDLE;
            end
         end
         S_LIST_SCAN: begin
            if (!sts.scan_busy && sts.out_free) begin
               ctl.load_out = 1'b1;
               ctl.out_sel = R_LIST_ELEM;
               ctl.out_last = sts.elem_last;
               ctl.elem_inc = 1'b1;
               if (sts.elem_last) begin
                  state_in = S_IDLE;
               end else begin
                  ctl.start_scan = 1'b1;
                  ctl.scan_cont = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: src/coe_sdo_dpath.sv
// datapath of the sdo object server: slot memory, scan unit, counters, result register
// depends on coe_sdo_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "coe_sdo_object_server_core_assert.svh"

module coe_sdo_dpath import coe_sdo_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   parameter int LIST_LIMIT  = 57
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_item,
   input  ctl_type ctl,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [5:0] LIMIT_N = 6'(LIST_LIMIT);
   localparam logic [5:0] LENGTHS_N =
      6'((LIST_LIMIT < LENGTHS_COUNT) ? LIST_LIMIT : LENGTHS_COUNT);

   slot_type slot_mem [TABLE_DEPTH];

   req_type        req_ff;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  ptr_ff;
   logic           busy_ff;
   logic           rv_ff;
   slot_type       rd_ff;
   logic [AW-1:0]  rd_idx_ff;
   logic [23:0]    key_ff;
   logic           hit_ff;
   logic [AW-1:0]  hit_slot_ff;
   logic [31:0]    hit_val_ff;
   logic [2:0]     hit_size_ff;
   logic           hit_wr_ff;
   logic           has_idx_ff;
   logic [7:0]     max_sub_ff;
   logic           first_ff;
   logic [15:0]    prev_ff;
   logic           got_ff;
   logic [15:0]    best_ff;
   logic [CW-1:0]  distinct_ff;
   logic [5:0]     elem_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic           issue;
   logic           out_free;
   logic [15:0]    rd_ix;
   logic [7:0]     rd_sb;
   logic [5:0]     n_list;
   logic [2:0]     nb;
   logic [31:0]    dl_value;
   logic [6:0]     opcode;
   logic [2:0]     ccs;
   req_class_type  cls;
   rsp_type        rsp_in;
   logic [1:0]     up_pad;

   assign issue    = busy_ff && (ptr_ff < count_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rd_ix    = rd_ff.key[23:8];
   assign rd_sb    = rd_ff.key[7:0];
   assign opcode   = req_ff.command_byte[6:0] & OP_MASK;
   assign ccs      = req_ff.command_byte[7:5];

   always_comb begin
      if (!req_ff.mode) begin
         cls = C_DEFINE;
      end else if (req_ff.request_length < MIN_LEN || req_ff.mailbox_type != MBX_COE) begin
         cls = C_IGNORE;
      end else if (req_ff.coe_service == SVC_INFO) begin
         if (opcode == OP_LIST)      cls = C_LIST;
         else if (opcode == OP_OBJ)  cls = C_OBJ;
         else if (opcode == OP_ENT)  cls = C_ENT;
         else                        cls = C_IGNORE;
      end else if (req_ff.coe_service == SVC_SDO) begin
         cls = (ccs == CCS_UPLOAD || ccs == CCS_DOWNLOAD) ? C_XFER : C_BAD;
      end else begin
         cls = C_IGNORE;
      end
   end

   // list element count sent after the header
   always_comb begin
      if (req_ff.object_index == LIST_LENGTHS) begin
         n_list = LENGTHS_N;
      end else if (req_ff.object_index == LIST_ALL) begin
         n_list = (32'(distinct_ff) >= 32'(LIST_LIMIT)) ? LIMIT_N : 6'(distinct_ff);
      end else begin
         n_list = 6'd0;
      end
   end

   // download bytes masked to the entry size and the request length
   always_comb begin
      nb = (hit_size_ff > 3'd4) ? 3'd4 : hit_size_ff;
      dl_value = 32'd0;
      for (int i = 0; i < 4; i++) begin
         if ((3'(i) < nb) && (8'(12 + i) < req_ff.request_length))
            dl_value[8*i +: 8] = req_ff.data_word[8*i +: 8];
      end
   end

   assign sts.cls        = cls;
   assign sts.scan_busy  = busy_ff;
   assign sts.hit        = hit_ff;
   assign sts.hit_wr     = hit_wr_ff;
   assign sts.is_upload  = (ccs == CCS_UPLOAD);
   assign sts.nx_got     = got_ff;
   assign sts.list_word0 = (req_ff.object_index == LIST_LENGTHS);
   assign sts.n_zero     = (n_list == 6'd0);
   assign sts.elem_last  = ((elem_ff + 6'd1) == n_list);
   assign sts.out_free   = out_free;

   always_ff @(posedge clock) begin
      if (ctl.capture) req_ff <= req_item;
   end

   // slot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.write_def) begin
         if (hit_ff) begin
            slot_mem[hit_slot_ff] <= '{key: key_ff, value: req_ff.data_word,
                                       size: req_ff.entry_size,
                                       writable: req_ff.entry_writable};
         end else if (32'(count_ff) < TABLE_DEPTH) begin
            slot_mem[count_ff[AW-1:0]] <= '{key: key_ff, value: req_ff.data_word,
                                           size: req_ff.entry_size,
                                           writable: req_ff.entry_writable};
         end
      end else if (ctl.write_dl) begin
         slot_mem[hit_slot_ff] <= '{key: key_ff, value: dl_value, size: hit_size_ff,
                                    writable: hit_wr_ff};
      end
      if (issue) begin
         rd_ff     <= slot_mem[ptr_ff[AW-1:0]];
         rd_idx_ff <= ptr_ff[AW-1:0];
      end
   end

   // slots fill in order and are never freed, so the fill count marks the valid ones
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.write_def && !hit_ff && (32'(count_ff) < TABLE_DEPTH)) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rv_ff   <= 1'b0;
         ptr_ff  <= '0;
         hit_ff  <= 1'b0;
         got_ff  <= 1'b0;
         first_ff <= 1'b1;
      end else if (ctl.start_scan) begin
         busy_ff    <= 1'b1;
         rv_ff      <= 1'b0;
         ptr_ff     <= '0;
         hit_ff     <= 1'b0;
         has_idx_ff <= 1'b0;
         max_sub_ff <= 8'd0;
         got_ff     <= 1'b0;
         if (ctl.key_obj) begin
            key_ff <= {req_ff.object_index, 7'd0, (max_sub_ff != 8'd0)};
         end else begin
            key_ff <= {req_ff.object_index, req_ff.sub_index};
         end
         if (ctl.scan_cont) begin
            prev_ff  <= best_ff;
            first_ff <= 1'b0;
         end else begin
            first_ff <= 1'b1;
         end
      end else begin
         rv_ff <= issue;
         if (issue) ptr_ff <= ptr_ff + CW'(1);
         if (!issue && !rv_ff) busy_ff <= 1'b0;
         if (rv_ff) begin
            if (rd_ff.key == key_ff) begin
               hit_ff      <= 1'b1;
               hit_slot_ff <= rd_idx_ff;
               hit_val_ff  <= rd_ff.value;
               hit_size_ff <= rd_ff.size;
               hit_wr_ff   <= rd_ff.writable;
            end
            if (rd_ix == key_ff[23:8]) begin
               has_idx_ff <= 1'b1;
               if (rd_sb > max_sub_ff) max_sub_ff <= rd_sb;
            end
            // smallest index above the previous one
            if ((first_ff || rd_ix > prev_ff) && (!got_ff || rd_ix < best_ff)) begin
               best_ff <= rd_ix;
               got_ff  <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         distinct_ff <= '0;
         elem_ff     <= 6'd0;
      end else begin
         if (ctl.cnt_clear)    distinct_ff <= '0;
         else if (ctl.cnt_inc) distinct_ff <= distinct_ff + CW'(1);
         if (ctl.list_init)     elem_ff <= 6'd0;
         else if (ctl.elem_inc) elem_ff <= elem_ff + 6'd1;
      end
   end

   assign up_pad = 2'(3'd4 - hit_size_ff);

   always_comb begin
      rsp_in = '0;
      rsp_in.index_out = req_ff.object_index;
      rsp_in.last      = ctl.out_last;
      case (ctl.out_sel)
         R_UPLOAD: begin
            rsp_in.response_kind = KIND_UPLOAD;
            rsp_in.control_out   = CMD_UPLOAD | {4'd0, up_pad, 2'd0};
            rsp_in.sub_out       = req_ff.sub_index;
            rsp_in.value_out     = hit_val_ff;
         end
         R_DL_ACK: begin
            rsp_in.response_kind = KIND_DL_ACK;
            rsp_in.control_out   = CMD_DL_ACK;
            rsp_in.sub_out       = req_ff.sub_index;
         end
         R_ABORT_MISS: begin
            rsp_in.response_kind = KIND_ABORT;
            rsp_in.control_out   = CMD_ABORT;
            rsp_in.sub_out       = req_ff.sub_index;
            rsp_in.value_out     = has_idx_ff ? ABORT_NO_SUB : ABORT_NO_OBJECT;
            rsp_in.abort_reason  = has_idx_ff ? REASON_NO_SUB : REASON_NO_OBJ;
         end
         R_ABORT_RO: begin
            rsp_in.response_kind = KIND_ABORT;
            rsp_in.control_out   = CMD_ABORT;
            rsp_in.sub_out       = req_ff.sub_index;
            rsp_in.value_out     = ABORT_READ_ONLY;
            rsp_in.abort_reason  = REASON_RO;
         end
         R_ABORT_BAD: begin
            rsp_in.response_kind = KIND_ABORT;
            rsp_in.control_out   = CMD_ABORT;
            rsp_in.sub_out       = req_ff.sub_index;
            rsp_in.value_out     = ABORT_BAD_CMD;
            rsp_in.abort_reason  = REASON_BAD_CMD;
         end
         R_LIST_HDR: begin
            rsp_in.response_kind = KIND_LIST_HDR;
            rsp_in.value_out     = 32'(n_list);
         end
         R_LIST_ELEM: begin
            rsp_in.response_kind = KIND_LIST_EL;
            if (req_ff.object_index == LIST_LENGTHS) begin
               rsp_in.value_out = (elem_ff == 6'd0) ? 32'(distinct_ff) : 32'd0;
            end else begin
               rsp_in.value_out = 32'(best_ff);
            end
         end
         R_OBJ_DESC: begin
            rsp_in.response_kind = KIND_OBJ_DESC;
            rsp_in.data_type     = hit_ff ? type_code(hit_size_ff) : 3'd0;
            rsp_in.highest_sub   = max_sub_ff;
            rsp_in.obj_code      = (max_sub_ff == 8'd0) ? OBJ_VAR : OBJ_ARRAY;
         end
         R_ENT_DESC: begin
            rsp_in.response_kind = KIND_ENT_DESC;
            rsp_in.sub_out       = req_ff.sub_index;
            rsp_in.data_type     = hit_ff ? type_code(hit_size_ff) : 3'd0;
            rsp_in.bit_length    = hit_ff ? {hit_size_ff, 3'd0} : 6'd0;
            rsp_in.access_flags  = (hit_ff && hit_wr_ff) ? (ACC_READ | ACC_WRITE) : ACC_READ;
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `COE_SDO_ASSERT_IMP(a_fill_bound, 1'b1, 32'(count_ff) <= TABLE_DEPTH, "fill count past depth")
   `COE_SDO_ASSERT_IMP(a_load_free, ctl.load_out, out_free, "result loaded over a held item")
   `COE_SDO_ASSERT_IMP(a_write_idle, ctl.write_def || ctl.write_dl, !busy_ff, "write during scan")
   `COE_SDO_ASSERT_NXT(a_scan_start, ctl.start_scan, busy_ff, "scan did not start")

endmodule

FILE: src/coe_sdo_object_server_core.sv
// top level of the expedited sdo object server
// depends on coe_sdo_pkg, coe_sdo_ctrl and coe_sdo_dpath
`timescale 1ns / 1ps

// req channel: one item either defines a dictionary entry (mode 0) or carries
// a parsed mailbox request (mode 1). rsp channel: results of a request, the
// final one flagged by last; defines and ignored requests give none.
// one item is worked at a time; req_ready is high only while the block waits.
// every lookup is a scan of the filled slots through the single slot memory
// read port; a define or sdo transfer takes one scan, an object description two.
// an index list takes one scan per distinct index, plus one that finds none, to
// count them, and for the full list one more scan per element sent.
// results leave through an output register; the next result is built while
// it is held, so a stalled receiver only pauses the sequence, nothing drops.
// reset empties the dictionary at once (fill count cleared, no clearing pass)
// and drops any result in flight.

module coe_sdo_object_server_core import coe_sdo_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   parameter int LIST_LIMIT  = 57
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   ctl_type ctl;
   sts_type sts;

   coe_sdo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   coe_sdo_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .LIST_LIMIT  (LIST_LIMIT)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
